/* rtl/core/jrdm_pkg.sv */
// jrdm_pkg: constants shared by the joystick radial dead-zone motion block
// register indexes, field widths, reset values and event codes
// no dependencies
package jrdm_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_SELECT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SELECT    = 3'd4;

  // register widths
  localparam int SPEED_W = 6;
  localparam int FULL_W  = 15;
  localparam int DZ_W    = 23;
  localparam int SEL_W   = 8;

  // register reset values
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 6'd20;
  localparam logic [FULL_W-1:0]  FULL_SCALE_RST  = 15'd32767;
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST   = 23'd838835;
  localparam logic [SEL_W-1:0]   X_SELECT_RST    = 8'd0;
  localparam logic [SEL_W-1:0]   Y_SELECT_RST    = 8'd1;

  // stream fields
  localparam int TYPE_W     = 8;
  localparam int NUM_W      = 8;
  localparam int VALUE_W    = 16;
  localparam int IN_DATA_W  = NUM_W + VALUE_W;
  localparam int STEP_W     = 7;
  localparam int OUT_DATA_W = 16;

  // quotient bits of speed and step divisions (results never exceed 63)
  localparam int Q_BITS = STEP_W - 1;

  // event type with the init flag masked off
  localparam logic [TYPE_W-2:0] EV_AXIS = 7'd2;

endpackage

/* rtl/core/joystick_radial_deadzone_motion_top.sv */
// joystick_radial_deadzone_motion_top: joystick events to radial dead-zone cursor steps
// bit-serial square root and shared bit-serial divider, one bit per cycle
// depends on jrdm_pkg
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: event_type; tdata: axis_number, axis_value
//  m_*       out        m_tvalid / m_tready  tdata: x_step, y_step
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one event at a time; the time from transfer to result is set by the root loop
// (one root bit per cycle), three divisions on one shared divider and any wait
// for the output register
// events inside the dead zone free the input right after the dead-zone check
// a held result sits in the output register; only the next result waits for it
// rst is synchronous: clears deflections, registers to their reset values
module joystick_radial_deadzone_motion_top #(
  parameter int AXIS_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // event_type [7:0]
  input  logic [jrdm_pkg::TYPE_W-1:0]         s_tuser,
  // axis_number [7:0], axis_value [23:8]
  input  logic [jrdm_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x_step [6:0], y_step [13:7], zero [15:14]
  output logic [jrdm_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jrdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jrdm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jrdm_pkg::*;

  localparam int RTW  = AXIS_BITS + FRAC_BITS;         // root width
  localparam int NW   = 2 * RTW;                       // radicand width
  localparam int RSW  = RTW + 2;                       // root remainder width
  localparam int SQW  = 2 * AXIS_BITS;                 // x*x + y*y width
  localparam int MW   = FULL_W + FRAC_BITS;            // full-scale width
  localparam int CW0  = (RTW > MW) ? RTW : MW;
  localparam int CW   = (CW0 > DZ_W) ? CW0 : DZ_W;     // magnitude compare width
  localparam int DVA  = CW + 8;
  localparam int DVB  = RTW + 7;
  localparam int DIVW = (DVA > DVB) ? DVA : DVB;       // divider width
  localparam int CNTW = $clog2(RTW + 1);
  localparam int PW   = Q_BITS + AXIS_BITS;            // step product width
  localparam int SPW  = Q_BITS + CW;                   // speed product width

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_SCALE, S_SPEED, S_DIV, S_LOAD, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_SPEED, PH_X, PH_Y} phase_t;

  state_t state;
  phase_t ph;

  // configuration registers
  logic [SPEED_W-1:0] speed_limit;
  logic [FULL_W-1:0]  full_scale;
  logic [DZ_W-1:0]    dead_zone;
  logic [SEL_W-1:0]   x_sel;
  logic [SEL_W-1:0]   y_sel;

  // stick state and datapath
  logic signed [AXIS_BITS-1:0] x_defl;
  logic signed [AXIS_BITS-1:0] y_defl;
  logic [SQW-1:0]    sq_x;
  logic [NW-1:0]     rad;
  logic [RSW-1:0]    sq_rem;
  logic [RTW-1:0]    root;
  logic [CW-1:0]     mag;
  logic [DIVW-1:0]   div_rem;
  logic [DIVW-1:0]   div_dsh;
  logic [Q_BITS-1:0] quo;
  logic [Q_BITS-1:0] spd;
  logic [Q_BITS-1:0] x_quo;
  logic [CNTW-1:0]   cnt;

  logic                        s_xfer;
  logic signed [AXIS_BITS-1:0] in_value;
  logic signed [AXIS_BITS-1:0] sq_op;
  logic signed [SQW-1:0]       sq_prod;
  logic [SQW-1:0]              sq_sum;
  logic [RSW-1:0]              rem_sh;
  logic [RSW-1:0]              trial;
  logic                        rt_ok;
  logic [CW-1:0]               root_ext;
  logic [CW-1:0]               fullq;
  logic [CW-1:0]               dz_ext;
  logic [CW-1:0]               dspan;
  logic [CW-1:0]               mag_clamp;
  logic [SPW-1:0]              spd_prod;
  logic signed [AXIS_BITS-1:0] st_axis;
  logic [Q_BITS-1:0]           st_spd;
  logic [AXIS_BITS-1:0]        st_abs;
  logic [PW-1:0]               st_prod;
  logic [DIVW-1:0]             st_num;
  logic [DIVW-1:0]             st_dsh;
  logic                        div_ok;
  logic [STEP_W-1:0]           x_step;
  logic [STEP_W-1:0]           y_step;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_xfer    = s_tvalid && s_tready;
  assign in_value  = s_tdata[NUM_W +: AXIS_BITS];

  // squaring, one axis per cycle
  assign sq_op   = (state == S_SQX) ? x_defl : y_defl;
  assign sq_prod = sq_op * sq_op;
  assign sq_sum  = sq_x + $unsigned(sq_prod);

  // one root bit per cycle, two radicand bits shifted in
  assign rem_sh = {sq_rem[RSW-3:0], rad[NW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign rt_ok  = (rem_sh >= trial);

  // clamp to full scale and dead-zone span
  assign root_ext  = CW'(root);
  assign fullq     = CW'({full_scale, {FRAC_BITS{1'b0}}});
  assign dz_ext    = CW'(dead_zone);
  assign dspan     = fullq - dz_ext;
  assign mag_clamp = (root_ext > fullq) ? fullq : root_ext;
  assign spd_prod  = SPW'(speed_limit) * SPW'(mag - dz_ext);

  // step numerator: 2 * speed * (|axis| << FRAC_BITS) + mag
  assign st_axis = (ph == PH_SPEED) ? x_defl : y_defl;
  assign st_spd  = (ph == PH_SPEED) ? quo : spd;
  assign st_abs  = st_axis[AXIS_BITS-1] ? (~$unsigned(st_axis) + 1'b1) : $unsigned(st_axis);
  assign st_prod = PW'(st_spd) * PW'(st_abs);
  assign st_num  = DIVW'({st_prod, {(FRAC_BITS + 1){1'b0}}}) + DIVW'(mag);
  assign st_dsh  = DIVW'({mag, {Q_BITS{1'b0}}});

  // restoring division step; saturates to all ones on overflow
  assign div_ok = (div_rem >= div_dsh);

  // signed steps from quotient magnitudes
  assign x_step = x_defl[AXIS_BITS-1] ? (~{1'b0, x_quo} + 1'b1) : {1'b0, x_quo};
  assign y_step = y_defl[AXIS_BITS-1] ? (~{1'b0, quo} + 1'b1) : {1'b0, quo};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= SPEED_LIMIT_RST;
      full_scale  <= FULL_SCALE_RST;
      dead_zone   <= DEAD_ZONE_RST;
      x_sel       <= X_SELECT_RST;
      y_sel       <= Y_SELECT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPEED_LIMIT: speed_limit <= cfg_data[SPEED_W-1:0];
        REG_FULL_SCALE:  full_scale  <= cfg_data[FULL_W-1:0];
        REG_DEAD_ZONE:   dead_zone   <= cfg_data[DZ_W-1:0];
        REG_X_SELECT:    x_sel       <= cfg_data[SEL_W-1:0];
        REG_Y_SELECT:    y_sel       <= cfg_data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ph       <= PH_SPEED;
      m_tvalid <= 1'b0;
      x_defl   <= '0;
      y_defl   <= '0;
      cnt      <= '0;
    end else begin
      // output state reloads the register itself
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            if (s_tuser[TYPE_W-2:0] == EV_AXIS) begin
              if (s_tdata[NUM_W-1:0] == x_sel) begin
                x_defl <= in_value;
              end else if (s_tdata[NUM_W-1:0] == y_sel) begin
                y_defl <= in_value;
              end
            end
            state <= S_SQX;
          end
        end
        S_SQX: begin
          sq_x  <= $unsigned(sq_prod);
          state <= S_SQY;
        end
        S_SQY: begin
          rad    <= {sq_sum, {(2 * FRAC_BITS){1'b0}}};
          sq_rem <= '0;
          root   <= '0;
          cnt    <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          sq_rem <= rt_ok ? (rem_sh - trial) : rem_sh;
          root   <= {root[RTW-2:0], rt_ok};
          rad    <= {rad[NW-3:0], 2'b00};
          cnt    <= cnt + 1'b1;
          if (cnt == CNTW'(RTW - 1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          mag   <= mag_clamp;
          state <= S_SPEED;
        end
        S_SPEED: begin
          // no result inside the dead zone
          if (mag <= dz_ext) begin
            state <= S_IDLE;
          end else begin
            div_rem <= DIVW'({spd_prod, 1'b0}) + DIVW'(dspan);
            div_dsh <= DIVW'({dspan, {Q_BITS{1'b0}}});
            cnt     <= '0;
            ph      <= PH_SPEED;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ok) begin
            div_rem <= div_rem - div_dsh;
          end
          quo     <= {quo[Q_BITS-2:0], div_ok};
          div_dsh <= div_dsh >> 1;
          cnt     <= cnt + 1'b1;
          if (cnt == CNTW'(Q_BITS - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt     <= '0;
          div_rem <= st_num;
          div_dsh <= st_dsh;
          unique case (ph)
            PH_SPEED: begin
              spd   <= quo;
              ph    <= PH_X;
              state <= S_DIV;
            end
            PH_X: begin
              x_quo <= quo;
              ph    <= PH_Y;
              state <= S_DIV;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'({y_step, x_step});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // input closes right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_tready)
    else $error("input ready stayed high after a transfer");

  // root remainder never exceeds twice the partial root
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (sq_rem <= RSW'({root, 1'b0})))
    else $error("square root remainder out of range");

  // radial speed never exceeds the configured maximum
  a_speed_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && ph == PH_X) |-> (spd <= speed_limit))
    else $error("speed above the configured limit");

  // divider runs exactly the quotient width
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt < CNTW'(Q_BITS)))
    else $error("divider ran past its quotient width");

  // a result appears only from the output state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("result valid raised outside the output state");
`endif

endmodule
